[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define BLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define BLS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[src/bls_pkg.sv]
`default_nettype none

package bls_pkg;

  localparam int unsigned DEPTH = 8;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = 4;
  localparam int unsigned OP_W  = 3;
  localparam int unsigned POS_W = 4;
  localparam int unsigned DW    = 32;
  localparam int unsigned ST_W  = 2;

  localparam logic [CNT_W-1:0] CAP_RESET = 4'd8;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 3'd0,
    OP_POP  = 3'd1,
    OP_READ = 3'd2,
    OP_PEEK = 3'd3,
    OP_EDIT = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_RESP = 2'd2
  } state_e;

  typedef struct packed {
    logic capture;
    logic exec;
  } dp_cmd_t;

endpackage

`default_nettype wire

[src/bls_ctrl.sv]
`default_nettype none

`include "assert_macros.svh"

module bls_ctrl
  import bls_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start,
  output dp_cmd_t      cmd_o,
  output logic         busy_o,
  output logic         done_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) state_d = S_EXEC;
      end
      S_EXEC: state_d = S_RESP;
      S_RESP: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.capture = 1'b0;
    cmd_o.exec    = 1'b0;
    busy_o        = 1'b1;
    done_o        = 1'b0;
    case (state_q)
      S_IDLE: begin
        busy_o        = 1'b0;
        cmd_o.capture = start;
      end
      S_EXEC: cmd_o.exec = 1'b1;
      S_RESP: done_o = 1'b1;
      default: busy_o = 1'b0;
    endcase
  end

  `BLS_ASSERT_ALWAYS(a_done_busy, done_o |-> busy_o, "result strobe while not busy")
  `BLS_ASSERT(a_accept_exec, (start && !busy_o) |=> cmd_o.exec, "accepted item not executed")
  `BLS_ASSERT(a_exec_done, cmd_o.exec |=> done_o, "executed item gave no result")
  `BLS_ASSERT(a_single_done, done_o |=> !done_o, "result strobe repeated")

endmodule

`default_nettype wire

[src/bls_dp.sv]
`default_nettype none

`include "assert_macros.svh"

module bls_dp
  import bls_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire dp_cmd_t                 cmd_i,
  input  wire logic [CNT_W-1:0]        capacity_i,
  input  wire logic [OP_W-1:0]         opcode_i,
  input  wire logic [POS_W-1:0]        position_i,
  input  wire logic signed [DW-1:0]    value_i,
  output logic signed [DW-1:0]         data_o,
  output logic [ST_W-1:0]              status_o,
  output logic [CNT_W-1:0]             count_o
);

  logic signed [DW-1:0] mem [DEPTH];

  logic [OP_W-1:0]      op_q;
  logic [POS_W-1:0]     pos_q;
  logic signed [DW-1:0] val_q;
  logic signed [DW-1:0] rd_q;

  logic [CNT_W-1:0] count_q, count_d;
  status_e          status_q, status_d;
  logic             rd_ok_q, rd_ok_d;

  logic [CNT_W-1:0] eff_cap;
  logic             we;
  logic [CNT_W-1:0] waddr, raddr;

  // capacity of zero behaves as one, above the built depth as the depth
  always_comb begin
    eff_cap = capacity_i;
    if (capacity_i == '0) eff_cap = CNT_W'(1);
    if (capacity_i > CNT_W'(DEPTH)) eff_cap = CNT_W'(DEPTH);
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_OK;
    rd_ok_d  = 1'b0;
    we       = 1'b0;
    waddr    = count_q;
    raddr    = CNT_W'(pos_q);
    case (op_e'(op_q))
      OP_PUSH: begin
        if (count_q >= eff_cap) begin
          status_d = ST_FULL;
        end else begin
          we      = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_POP: begin
        raddr = count_q - CNT_W'(1);
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          rd_ok_d = 1'b1;
          count_d = count_q - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (count_q == '0) status_d = ST_EMPTY;
        else if (CNT_W'(pos_q) >= count_q) status_d = ST_BADPOS;
        else rd_ok_d = 1'b1;
      end
      OP_PEEK: begin
        // top-relative: position one is the newest entry
        raddr = count_q - CNT_W'(pos_q);
        if (count_q == '0) status_d = ST_EMPTY;
        else if (pos_q == '0 || CNT_W'(pos_q) > count_q) status_d = ST_BADPOS;
        else rd_ok_d = 1'b1;
      end
      OP_EDIT: begin
        waddr = CNT_W'(pos_q);
        if (count_q == '0) status_d = ST_EMPTY;
        else if (CNT_W'(pos_q) >= count_q) status_d = ST_BADPOS;
        else we = 1'b1;
      end
      default: status_d = ST_BADPOS;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= opcode_i;
      pos_q <= position_i;
      val_q <= value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && we) mem[waddr[AW-1:0]] <= val_q;
    if (cmd_i.exec) rd_q <= mem[raddr[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      status_q <= ST_OK;
      rd_ok_q  <= 1'b0;
    end else if (cmd_i.exec) begin
      count_q  <= count_d;
      status_q <= status_d;
      rd_ok_q  <= rd_ok_d;
    end
  end

  assign data_o   = rd_ok_q ? rd_q : '0;
  assign status_o = status_q;
  assign count_o  = count_q;

  `BLS_ASSERT(a_cnt_bound, count_q <= CNT_W'(DEPTH), "entry count above depth")
  `BLS_ASSERT(a_cnt_hold, !cmd_i.exec |=> $stable(count_q), "count moved outside execution")
  `BLS_ASSERT(a_rd_ok, rd_ok_q |-> (status_q == ST_OK), "data returned with error status")

endmodule

`default_nettype wire

[src/bounded_lifo_stack.sv]
// Bounded LIFO stack of signed 32-bit words with a capacity set through the APB register at
// address 0 (reset 8; 0 acts as 1, above 8 acts as 8). A request is taken when start is high
// and busy is low; each request passes through capture, one access of the entry memory (one
// write and one read address, registered read data) and result, and busy is high during the
// access and result steps. The result appears on data_o, status_o and count_o for exactly one
// cycle with done_o high; the receiver cannot stall it, so it must take the item in that cycle.
// A new request can be taken in the cycle after done_o, not before. Entries are not cleared at
// reset; only entries below the count are ever returned on data_o.

`default_nettype none

module bounded_lifo_stack
  import bls_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [OP_W-1:0]       opcode_i,
  input  wire logic [POS_W-1:0]      position_i,
  input  wire logic signed [DW-1:0]  value_i,
  output logic                       done_o,
  output logic signed [DW-1:0]       data_o,
  output logic [ST_W-1:0]            status_o,
  output logic [CNT_W-1:0]           count_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  dp_cmd_t          cmd;
  logic [CNT_W-1:0] capacity_q;
  logic             cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (cfg_we) begin
      capacity_q <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == 1'b0) ? {{(32-CNT_W){1'b0}}, capacity_q} : '0;

  bls_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (done_o)
  );

  bls_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .capacity_i (capacity_q),
    .opcode_i   (opcode_i),
    .position_i (position_i),
    .value_i    (value_i),
    .data_o     (data_o),
    .status_o   (status_o),
    .count_o    (count_o)
  );

endmodule

`default_nettype wire

[tb/tb_bounded_lifo_stack.sv]
`timescale 1ns / 100ps

module tb_bounded_lifo_stack;
  import bls_pkg::*;

  localparam logic [2:0]           CAP_ADDR    = 3'd0;
  localparam logic [OP_W-1:0]      OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0]      OP_SPARE_HI = 3'd7;
  localparam logic signed [DW-1:0] WORD_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [DW-1:0] WORD_MIN    = 32'sh8000_0000;
  localparam int unsigned          CYCLE_LIMIT = 200000;
  localparam int unsigned          MAX_REPORTS = 10;

  typedef struct {
    logic signed [DW-1:0] data;
    status_e              status;
    logic [CNT_W-1:0]     count;
  } stack_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [OP_W-1:0]      opcode_i = '0;
  logic [POS_W-1:0]     position_i = '0;
  logic signed [DW-1:0] value_i = '0;
  logic                 done_o;
  logic signed [DW-1:0] data_o;
  logic [ST_W-1:0]      status_o;
  logic [CNT_W-1:0]     count_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [2:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  bounded_lifo_stack dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .opcode_i   (opcode_i),
    .position_i (position_i),
    .value_i    (value_i),
    .done_o     (done_o),
    .data_o     (data_o),
    .status_o   (status_o),
    .count_o    (count_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk_i = ~clk_i;

  // predicted stack contents and settings
  logic signed [DW-1:0] stack_words [DEPTH];
  logic [CNT_W-1:0]     stack_fill;
  logic [CNT_W-1:0]     cap_reg;

  stack_result_t pending_results[$];
  stack_result_t oldest_result;
  int unsigned   requests_sent;
  int unsigned   results_checked;
  int unsigned   cap_writes;
  int unsigned   mismatches;
  int unsigned   cycle_count;

  function automatic stack_result_t apply_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                                  logic signed [DW-1:0] val);
    stack_result_t r;
    int unsigned   room;
    r.data   = '0;
    r.status = ST_OK;
    room = (cap_reg == 0) ? 1 : ((cap_reg > DEPTH) ? DEPTH : cap_reg);
    case (op)
      OP_PUSH: begin
        if (stack_fill >= room) r.status = ST_FULL;
        else begin
          stack_words[stack_fill] = val;
          stack_fill = stack_fill + 1'b1;
        end
      end
      OP_POP: begin
        if (stack_fill == 0) r.status = ST_EMPTY;
        else begin
          r.data = stack_words[stack_fill - 1'b1];
          stack_fill = stack_fill - 1'b1;
        end
      end
      OP_READ: begin
        if (stack_fill == 0) r.status = ST_EMPTY;
        else if (pos >= stack_fill) r.status = ST_BADPOS;
        else r.data = stack_words[pos];
      end
      OP_PEEK: begin
        if (stack_fill == 0) r.status = ST_EMPTY;
        else if (pos == 0 || pos > stack_fill) r.status = ST_BADPOS;
        else r.data = stack_words[stack_fill - pos];
      end
      OP_EDIT: begin
        if (stack_fill == 0) r.status = ST_EMPTY;
        else if (pos >= stack_fill) r.status = ST_BADPOS;
        else stack_words[pos] = val;
      end
      default: r.status = ST_BADPOS;
    endcase
    r.count = stack_fill;
    return r;
  endfunction

  task automatic send_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                              logic signed [DW-1:0] val);
    start      <= 1'b1;
    opcode_i   <= op;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_results.push_back(apply_request(op, pos, val));
    requests_sent++;
  endtask

  // drop start and let every outstanding result come back
  task automatic drain_stack_port();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CNT_W-1:0] cap);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= {28'($urandom), cap};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cap_reg = cap;
    cap_writes++;
  endtask

  function automatic logic signed [DW-1:0] pick_word();
    case ($urandom_range(15))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_request();
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    int unsigned      r;
    r = $urandom_range(99);
    if (r < 32) op = OP_PUSH;
    else if (r < 60) op = OP_POP;
    else if (r < 73) op = OP_READ;
    else if (r < 85) op = OP_PEEK;
    else if (r < 97) op = OP_EDIT;
    else op = OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    // mostly positions that hit a live entry, the rest anywhere in the field
    if (stack_fill != 0 && $urandom_range(9) < 8) begin
      if (op == OP_PEEK) pos = POS_W'($urandom_range(stack_fill, 1));
      else pos = POS_W'($urandom_range(stack_fill - 1'b1, 0));
    end else begin
      pos = POS_W'($urandom_range(15));
    end
    send_request(op, pos, pick_word());
  endtask

  task automatic test_empty_stack();
    send_request(OP_POP, 4'd0, '0);
    send_request(OP_READ, 4'd0, '0);
    send_request(OP_PEEK, 4'd1, '0);
    send_request(OP_EDIT, 4'd0, WORD_MAX);
    send_request(OP_SPARE_LO, 4'd0, $urandom);
    send_request(OP_SPARE_HI, 4'd15, $urandom);
    drain_stack_port();
  endtask

  task automatic test_push_and_access();
    send_request(OP_PUSH, 4'd0, WORD_MAX);
    send_request(OP_PUSH, 4'd15, WORD_MIN);
    send_request(OP_PUSH, 4'd0, '1);
    send_request(OP_PUSH, 4'd0, '0);
    send_request(OP_PEEK, 4'd0, '0);
    send_request(OP_PEEK, 4'd1, '0);
    send_request(OP_PEEK, 4'd4, '0);
    send_request(OP_PEEK, 4'd5, '0);
    send_request(OP_READ, 4'd0, '0);
    send_request(OP_READ, 4'd4, '0);
    send_request(OP_READ, 4'd15, '0);
    send_request(OP_EDIT, 4'd1, 32'sh5A5A_A5A5);
    send_request(OP_EDIT, 4'd8, WORD_MIN);
    send_request(OP_READ, 4'd1, '0);
    send_request(OP_POP, 4'd0, '0);
    drain_stack_port();
  endtask

  // capacity dropped below the count, then zero which acts as one
  task automatic test_capacity_limits();
    write_capacity(4'd2);
    send_request(OP_PUSH, 4'd0, 32'sh1234_5678);
    send_request(OP_POP, 4'd0, '0);
    send_request(OP_PUSH, 4'd0, 32'sh1234_5678);
    send_request(OP_POP, 4'd0, '0);
    send_request(OP_PUSH, 4'd0, WORD_MIN);
    drain_stack_port();
    write_capacity(4'd0);
    send_request(OP_PUSH, 4'd0, WORD_MAX);
    send_request(OP_POP, 4'd0, '0);
    send_request(OP_POP, 4'd0, '0);
    send_request(OP_PUSH, 4'd0, WORD_MAX);
    drain_stack_port();
  endtask

  task automatic test_random_traffic(int unsigned idle_pct, int unsigned n_items);
    logic [CNT_W-1:0] cap;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        drain_stack_port();
        case ($urandom_range(7))
          0: cap = 4'd0;
          1: cap = 4'd1;
          2: cap = 4'd8;
          3: cap = 4'd15;
          default: cap = CNT_W'($urandom_range(15));
        endcase
        write_capacity(cap);
      end
      if ($urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        repeat ($urandom_range(4, 1)) @(posedge clk_i);
      end
      random_request();
    end
    drain_stack_port();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: unexpected result data=%0d status=%0d count=%0d",
                   data_o, status_o, count_o);
      end else begin
        oldest_result = pending_results.pop_front();
        results_checked++;
        if (data_o !== oldest_result.data || status_o !== oldest_result.status ||
            count_o !== oldest_result.count) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: data %0d/%0d status %0d/%0d count %0d/%0d (expected/actual)",
                     oldest_result.data, data_o, oldest_result.status, status_o,
                     oldest_result.count, count_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    foreach (stack_words[i]) stack_words[i] = '0;
    stack_fill = '0;
    cap_reg    = CAP_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_stack();
    test_push_and_access();
    test_capacity_limits();
    test_random_traffic(35, 400);
    test_random_traffic(62, 400);
    test_random_traffic(0, 400);

    if (pending_results.size() != 0) mismatches++;
    $display("%0d requests over %0d capacity writes, sender gaps at 35, 62 and 0 percent",
             requests_sent, cap_writes);
    $display("%0d results checked, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
